[rtl/tasm_pkg.sv]
// ----------------------------------------------------------------------------
// tasm_pkg
// Shared types, codes and reset values for the Type-C attach state machine.
// ----------------------------------------------------------------------------
package tasm_pkg;

   localparam int TIMER_BITS_DEF = 16;
   localparam int TICK_W         = 16;
   localparam int CSR_IDX_W      = 3;

   typedef enum logic [5:0] {
      ST_DIS_SNK   = 6'b000001,
      ST_DIS_SRC   = 6'b000010,
      ST_DIS_DRP   = 6'b000100,
      ST_UNATT_SNK = 6'b001000,
      ST_ATT_SNK   = 6'b010000,
      ST_ATT_SRC   = 6'b100000
   } st_type;

   localparam logic [2:0] CODE_DIS_SNK   = 3'd0;
   localparam logic [2:0] CODE_DIS_SRC   = 3'd1;
   localparam logic [2:0] CODE_DIS_DRP   = 3'd2;
   localparam logic [2:0] CODE_UNATT_SNK = 3'd3;
   localparam logic [2:0] CODE_ATT_SNK   = 3'd4;
   localparam logic [2:0] CODE_ATT_SRC   = 3'd6;

   localparam logic [1:0] MODE_DRP = 2'd1;
   localparam logic [1:0] MODE_SNK = 2'd2;
   localparam logic [1:0] MODE_SRC = 2'd3;

   localparam logic [1:0] FUNC_TOGGLE  = 2'd0;
   localparam logic [1:0] FUNC_COMP    = 2'd1;
   localparam logic [1:0] FUNC_TICK    = 2'd2;
   localparam logic [1:0] FUNC_RESTART = 2'd3;

   localparam logic [2:0] TRES_SRC_CC1 = 3'd1;
   localparam logic [2:0] TRES_SRC_CC2 = 3'd2;
   localparam logic [2:0] TRES_SNK_CC1 = 3'd5;
   localparam logic [2:0] TRES_SNK_CC2 = 3'd6;

   localparam logic [1:0] KIND_SRC = 2'd0;
   localparam logic [1:0] KIND_SNK = 2'd1;
   localparam logic [1:0] KIND_DRP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PORT_KIND  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREF_ROLE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRY        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRY_WAIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOGGLE_CYC = 3'd4;

   localparam logic [TICK_W-1:0] RST_TRY_TICKS      = 16'd75;
   localparam logic [TICK_W-1:0] RST_TRY_WAIT_TICKS = 16'd400;
   localparam logic [TICK_W-1:0] RST_TOGGLE_TICKS   = 16'd140;

   typedef struct packed {
      logic [1:0]        port_kind;
      logic              role_pref;
      logic [TICK_W-1:0] try_ticks;
      logic [TICK_W-1:0] try_wait_ticks;
      logic [TICK_W-1:0] toggle_cycle_ticks;
   } cfg_type;

   typedef struct packed {
      st_type     state;
      logic [1:0] mode;
      logic       timeout_armed;
      logic       fallback_armed;
   } ctl_type;

   function automatic logic [2:0] state_code(st_type s);
      logic [2:0] c;
      unique case (s)
         ST_DIS_SNK:   c = CODE_DIS_SNK;
         ST_DIS_SRC:   c = CODE_DIS_SRC;
         ST_DIS_DRP:   c = CODE_DIS_DRP;
         ST_UNATT_SNK: c = CODE_UNATT_SNK;
         ST_ATT_SNK:   c = CODE_ATT_SNK;
         ST_ATT_SRC:   c = CODE_ATT_SRC;
         default:      c = CODE_DIS_DRP;
      endcase
      return c;
   endfunction

endpackage

[rtl/tasm_csr.sv]
// ----------------------------------------------------------------------------
// tasm_csr
// Configuration registers: port kind, role preference and timer lengths.
// ----------------------------------------------------------------------------
module tasm_csr
   import tasm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PORT_KIND:  cfg_in.port_kind          = csr_data[1:0];
            CSR_PREF_ROLE:  cfg_in.role_pref          = csr_data[0];
            CSR_TRY:        cfg_in.try_ticks          = csr_data;
            CSR_TRY_WAIT:   cfg_in.try_wait_ticks     = csr_data;
            CSR_TOGGLE_CYC: cfg_in.toggle_cycle_ticks = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_kind          <= KIND_DRP;
         cfg_ff.role_pref          <= 1'b0;
         cfg_ff.try_ticks          <= RST_TRY_TICKS;
         cfg_ff.try_wait_ticks     <= RST_TRY_WAIT_TICKS;
         cfg_ff.toggle_cycle_ticks <= RST_TOGGLE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/tasm_step.sv]
// ----------------------------------------------------------------------------
// tasm_step
// Next-state logic for one event: transitions, timer arm, count and expiry.
// ----------------------------------------------------------------------------
module tasm_step
   import tasm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
   input  cfg_type               cfg,
   input  ctl_type               ctl,
   input  logic [TIMER_BITS-1:0] timeout_left,
   input  logic [TIMER_BITS-1:0] fallback_left,
   input  logic [1:0]            func,
   input  logic [2:0]            toggle_result,
   input  logic                  cmp_detach,
   output ctl_type               ctl_nxt,
   output logic [TIMER_BITS-1:0] timeout_left_nxt,
   output logic [TIMER_BITS-1:0] fallback_left_nxt,
   output logic                  pulse,
   output logic                  changed
);

   localparam int LW = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
   localparam logic [LW-1:0] TMR_MAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

   function automatic logic [TIMER_BITS-1:0] load_len(logic [TICK_W-1:0] n);
      logic [LW-1:0] w;
      logic [LW-1:0] r;
      w = LW'(n);
      if (w == '0) begin
         r = LW'(1);
      end else if (w > TMR_MAX) begin
         r = TMR_MAX;
      end else begin
         r = w;
      end
      return r[TIMER_BITS-1:0];
   endfunction

   logic                  src_found;
   logic                  snk_found;
   logic [TIMER_BITS-1:0] t_dec;
   logic [TIMER_BITS-1:0] f_dec;
   logic                  t_due;
   logic                  f_due;
   st_type                dis_state;
   st_type                go;
   logic                  go_en;

   assign src_found = (toggle_result == TRES_SRC_CC1) || (toggle_result == TRES_SRC_CC2);
   assign snk_found = (toggle_result == TRES_SNK_CC1) || (toggle_result == TRES_SNK_CC2);
   assign t_dec     = timeout_left - TIMER_BITS'(1);
   assign f_dec     = fallback_left - TIMER_BITS'(1);
   assign t_due     = ctl.timeout_armed && (t_dec == '0);
   assign f_due     = ctl.fallback_armed && (f_dec == '0);

   always_comb begin
      unique case (cfg.port_kind)
         KIND_SRC: dis_state = ST_DIS_SRC;
         KIND_SNK: dis_state = ST_DIS_SNK;
         default:  dis_state = ST_DIS_DRP;
      endcase
   end

   always_comb begin
      ctl_nxt           = ctl;
      timeout_left_nxt  = timeout_left;
      fallback_left_nxt = fallback_left;
      pulse             = 1'b0;
      go                = ctl.state;
      go_en             = 1'b0;

      unique case (func)
         FUNC_TOGGLE: begin
            unique case (ctl.state)
               ST_DIS_SNK: begin
                  if (snk_found) begin
                     go_en = 1'b1;
                     go    = ST_UNATT_SNK;
                  end
               end
               ST_DIS_SRC: begin
                  if (src_found) begin
                     go_en = 1'b1;
                     go    = ST_ATT_SRC;
                  end
               end
               ST_DIS_DRP: begin
                  if (snk_found) begin
                     go_en = 1'b1;
                     go    = cfg.role_pref ? ST_DIS_SRC : ST_UNATT_SNK;
                  end else if (src_found) begin
                     go_en = 1'b1;
                     go    = cfg.role_pref ? ST_ATT_SRC : ST_DIS_SNK;
                     pulse = !cfg.role_pref;
                  end
               end
               default: go_en = 1'b0;
            endcase
         end
         FUNC_COMP: begin
            if ((ctl.state == ST_ATT_SRC) && cmp_detach) begin
               go_en = 1'b1;
               go    = dis_state;
            end
         end
         FUNC_TICK: begin
            if (ctl.timeout_armed) begin
               timeout_left_nxt      = t_dec;
               ctl_nxt.timeout_armed = !t_due;
            end
            if (ctl.fallback_armed) begin
               fallback_left_nxt      = f_dec;
               ctl_nxt.fallback_armed = !f_due;
            end
            if (t_due && (ctl.state == ST_DIS_SNK)) begin
               go_en = 1'b1;
               go    = ST_DIS_SRC;
            end else if (t_due && (ctl.state == ST_DIS_SRC)) begin
               go_en = 1'b1;
               go    = ST_DIS_SNK;
            end else if (f_due && ((ctl.state == ST_DIS_SNK) || (ctl.state == ST_DIS_SRC))) begin
               go_en = 1'b1;
               go    = ST_DIS_DRP;
            end
         end
         FUNC_RESTART: begin
            go_en = 1'b1;
            go    = dis_state;
         end
      endcase

      if (go_en) begin
         ctl_nxt.state          = go;
         ctl_nxt.timeout_armed  = 1'b0;
         ctl_nxt.fallback_armed = 1'b0;
         timeout_left_nxt       = '0;
         fallback_left_nxt      = '0;
         if (go == ST_DIS_SNK) begin
            ctl_nxt.mode = MODE_SNK;
         end else if (go == ST_DIS_SRC) begin
            ctl_nxt.mode = MODE_SRC;
         end else if (go == ST_DIS_DRP) begin
            ctl_nxt.mode = MODE_DRP;
         end
         // arm the try, toggle-cycle or fallback timer that follows the move
         if (func == FUNC_TOGGLE && go == ST_DIS_SRC && ctl.state == ST_DIS_DRP) begin
            ctl_nxt.timeout_armed = 1'b1;
            timeout_left_nxt      = load_len(cfg.try_ticks);
         end else if (func == FUNC_TOGGLE && go == ST_DIS_SNK) begin
            ctl_nxt.timeout_armed = 1'b1;
            timeout_left_nxt      = load_len(cfg.toggle_cycle_ticks);
         end else if (func == FUNC_TICK && go != ST_DIS_DRP) begin
            ctl_nxt.fallback_armed = 1'b1;
            fallback_left_nxt      = load_len(cfg.try_wait_ticks);
         end
      end
      changed = go_en;
   end

endmodule

[rtl/typec_attach_state_machine.sv]
// ----------------------------------------------------------------------------
// typec_attach_state_machine
// USB Type-C attach state machine for one dual-role capable port.
// ----------------------------------------------------------------------------
// Events enter on the req_ channel (valid/ready): toggle done with its
// result code, comparator change, timer tick, or restart. Each
// event yields exactly one rsp_ beat with the connection state, the toggle
// mode, the pulldown pulse, both timer-armed flags and a changed flag.
// The csr_ channel writes port kind, role preference and the three timer
// lengths (in ticks); csr_ready is always high, write only while idle.
// An event is taken into an input register, evaluated against the state
// registers and written into the response register with the new state.
// One event per cycle is sustained while rsp_ready stays high; the state
// update is a loop from the state registers through the step logic.
// With a beat waiting and rsp_ready low the response register holds, one
// more event waits in the input register and req_ready drops till it moves.
// Synchronous reset enters disabled dual-role with dual-role toggling,
// both timers idle and registers at their defaults.
// ----------------------------------------------------------------------------
module typec_attach_state_machine
   import tasm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_func,
   input  logic [2:0]           req_toggle_result,
   input  logic                 req_cmp_detach,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_conn_state,
   output logic [1:0]           rsp_toggle_mode,
   output logic                 rsp_pulldown_pulse,
   output logic                 rsp_timeout_running,
   output logic                 rsp_fallback_running,
   output logic                 rsp_changed,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data
);

   cfg_type               cfg;
   ctl_type               ctl_ff;
   ctl_type               ctl_in;
   logic [TIMER_BITS-1:0] timeout_left_ff;
   logic [TIMER_BITS-1:0] timeout_left_in;
   logic [TIMER_BITS-1:0] fallback_left_ff;
   logic [TIMER_BITS-1:0] fallback_left_in;
   logic                  in_valid_ff;
   logic [1:0]            func_ff;
   logic [2:0]            tres_ff;
   logic                  comp_ff;
   logic                  rsp_valid_ff;
   logic [2:0]            conn_state_ff;
   logic [1:0]            toggle_mode_ff;
   logic                  pulse_ff;
   logic                  timeout_run_ff;
   logic                  fallback_run_ff;
   logic                  changed_ff;
   logic                  pulse_in;
   logic                  changed_in;
   logic                  advance;

   tasm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tasm_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .cfg               (cfg),
      .ctl               (ctl_ff),
      .timeout_left      (timeout_left_ff),
      .fallback_left     (fallback_left_ff),
      .func              (func_ff),
      .toggle_result     (tres_ff),
      .cmp_detach        (comp_ff),
      .ctl_nxt           (ctl_in),
      .timeout_left_nxt  (timeout_left_in),
      .fallback_left_nxt (fallback_left_in),
      .pulse             (pulse_in),
      .changed           (changed_in)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         tres_ff <= req_toggle_result;
         comp_ff <= req_cmp_detach;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.state          <= ST_DIS_DRP;
         ctl_ff.mode           <= MODE_DRP;
         ctl_ff.timeout_armed  <= 1'b0;
         ctl_ff.fallback_armed <= 1'b0;
         timeout_left_ff       <= '0;
         fallback_left_ff      <= '0;
      end else if (advance) begin
         ctl_ff           <= ctl_in;
         timeout_left_ff  <= timeout_left_in;
         fallback_left_ff <= fallback_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         conn_state_ff   <= state_code(ctl_in.state);
         toggle_mode_ff  <= ctl_in.mode;
         pulse_ff        <= pulse_in;
         timeout_run_ff  <= ctl_in.timeout_armed;
         fallback_run_ff <= ctl_in.fallback_armed;
         changed_ff      <= changed_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_conn_state       = conn_state_ff;
   assign rsp_toggle_mode      = toggle_mode_ff;
   assign rsp_pulldown_pulse   = pulse_ff;
   assign rsp_timeout_running  = timeout_run_ff;
   assign rsp_fallback_running = fallback_run_ff;
   assign rsp_changed          = changed_ff;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Type-C attach state machine.
// ----------------------------------------------------------------------------
// Events go in on the req_ channel and each one returns one rsp_ beat. A
// shadow copy of the attach logic tracks state, toggle mode and both timers
// and predicts every beat. A short directed list covers the ignored codes, the
// try-source and try-sink fallbacks, zero-length timers, all port kinds and
// an unused register index. Random phases then load new settings, the
// extremes among them, and drive mostly well-formed event streams with random
// idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import tasm_pkg::*;

   localparam logic [2:0]           TRES_IDLE  = 3'd0;
   localparam logic [2:0]           TRES_RSVD  = 3'd4;
   localparam logic [1:0]           KIND_ALT   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic                 ROW_EVT    = 1'b0;
   localparam logic                 ROW_CSR    = 1'b1;

   // pulse, timeout, fallback, changed in the low four bits
   typedef struct packed {
      logic [2:0] conn_state;
      logic [1:0] toggle_mode;
      logic       pulldown_pulse;
      logic       timeout_running;
      logic       fallback_running;
      logic       changed;
   } attach_report_type;

   typedef struct packed {
      logic              is_csr;
      logic [2:0]        sel;
      logic [2:0]        tres;
      logic              comp;
      logic [15:0]       data;
      logic              typed;
      attach_report_type want;
   } plan_row_type;

   localparam attach_report_type NO_WANT = '0;

   localparam plan_row_type PLAN [32] = '{
      '{ROW_EVT, {1'b0, FUNC_TICK}, TRES_IDLE, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_DRP, MODE_DRP, 4'b0000}},
      '{ROW_EVT, {1'b0, FUNC_TOGGLE}, TRES_IDLE, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_DRP, MODE_DRP, 4'b0000}},
      '{ROW_EVT, {1'b0, FUNC_COMP}, TRES_IDLE, 1'b1, 16'd0, 1'b1,
        {CODE_DIS_DRP, MODE_DRP, 4'b0000}},
      '{ROW_EVT, {1'b0, FUNC_TOGGLE}, TRES_SRC_CC1, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_SNK, MODE_SNK, 4'b1101}},
      '{ROW_EVT, {1'b0, FUNC_TOGGLE}, TRES_SNK_CC2, 1'b0, 16'd0, 1'b1,
        {CODE_UNATT_SNK, MODE_SNK, 4'b0001}},
      '{ROW_EVT, {1'b0, FUNC_COMP}, TRES_IDLE, 1'b1, 16'd0, 1'b1,
        {CODE_UNATT_SNK, MODE_SNK, 4'b0000}},
      '{ROW_EVT, {1'b0, FUNC_RESTART}, TRES_IDLE, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_DRP, MODE_DRP, 4'b0001}},
      '{ROW_CSR, CSR_TOGGLE_CYC, TRES_IDLE, 1'b0, 16'd0, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_TRY_WAIT, TRES_IDLE, 1'b0, 16'd1, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_TOGGLE}, TRES_SRC_CC2, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_SNK, MODE_SNK, 4'b1101}},
      '{ROW_EVT, {1'b0, FUNC_TICK}, TRES_IDLE, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_SRC, MODE_SRC, 4'b0011}},
      '{ROW_EVT, {1'b0, FUNC_TOGGLE}, TRES_RSVD, 1'b1, 16'd0, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_TICK}, TRES_IDLE, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_DRP, MODE_DRP, 4'b0001}},
      '{ROW_CSR, CSR_PREF_ROLE, TRES_IDLE, 1'b0, 16'd1, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_TRY, TRES_IDLE, 1'b0, 16'd2, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_TOGGLE}, TRES_SNK_CC1, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_SRC, MODE_SRC, 4'b0101}},
      '{ROW_EVT, {1'b0, FUNC_TICK}, TRES_IDLE, 1'b0, 16'd0, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_TICK}, TRES_IDLE, 1'b1, 16'd0, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_TICK}, TRES_SNK_CC1, 1'b0, 16'd0, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_TOGGLE}, TRES_SRC_CC1, 1'b0, 16'd0, 1'b1,
        {CODE_ATT_SRC, MODE_DRP, 4'b0001}},
      '{ROW_EVT, {1'b0, FUNC_COMP}, TRES_IDLE, 1'b0, 16'd0, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_COMP}, TRES_IDLE, 1'b1, 16'd0, 1'b1,
        {CODE_DIS_DRP, MODE_DRP, 4'b0001}},
      '{ROW_CSR, CSR_PORT_KIND, TRES_IDLE, 1'b0, {14'd0, KIND_SRC}, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_RESTART}, TRES_IDLE, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_SRC, MODE_SRC, 4'b0001}},
      '{ROW_EVT, {1'b0, FUNC_TOGGLE}, TRES_SRC_CC2, 1'b0, 16'd0, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_COMP}, TRES_IDLE, 1'b1, 16'd0, 1'b1,
        {CODE_DIS_SRC, MODE_SRC, 4'b0001}},
      '{ROW_CSR, CSR_PORT_KIND, TRES_IDLE, 1'b0, {14'd0, KIND_SNK}, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_RESTART}, TRES_IDLE, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_SNK, MODE_SNK, 4'b0001}},
      '{ROW_CSR, CSR_PORT_KIND, TRES_IDLE, 1'b0, 16'hFFFF, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_UNUSED, TRES_IDLE, 1'b0, 16'hA5A5, 1'b0, NO_WANT},
      '{ROW_EVT, {1'b0, FUNC_RESTART}, TRES_IDLE, 1'b0, 16'd0, 1'b1,
        {CODE_DIS_DRP, MODE_DRP, 4'b0001}},
      '{ROW_EVT, {1'b0, FUNC_RESTART}, TRES_IDLE, 1'b1, 16'd0, 1'b0, NO_WANT}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_func = FUNC_TICK;
   logic [2:0]           req_toggle_result = TRES_IDLE;
   logic                 req_cmp_detach = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [2:0]           rsp_conn_state;
   logic [1:0]           rsp_toggle_mode;
   logic                 rsp_pulldown_pulse;
   logic                 rsp_timeout_running;
   logic                 rsp_fallback_running;
   logic                 rsp_changed;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PORT_KIND;
   logic [TICK_W-1:0]    csr_data = '0;

   // shadow settings and attach state
   logic [1:0]  kind_cfg  = KIND_DRP;
   logic        pref_cfg  = 1'b0;
   logic [15:0] try_len   = RST_TRY_TICKS;
   logic [15:0] wait_len  = RST_TRY_WAIT_TICKS;
   logic [15:0] cycle_len = RST_TOGGLE_TICKS;
   logic [2:0]  st_now    = CODE_DIS_DRP;
   logic [1:0]  mode_now  = MODE_DRP;
   logic [15:0] tmo_cnt   = '0;
   logic        tmo_on    = 1'b0;
   logic [15:0] fb_cnt    = '0;
   logic        fb_on     = 1'b0;
   logic        moved     = 1'b0;

   attach_report_type report_q [$];
   int                fail_count = 0;
   logic              no_idle = 1'b0;
   logic              req_hot = 1'b0;
   logic              csr_hot = 1'b0;

   typec_attach_state_machine dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("** typec_attach_state_machine: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 21);
   end

   function automatic logic [15:0] timer_len(logic [15:0] n);
      return (n == 16'd0) ? 16'd1 : n;
   endfunction

   function automatic void enter_state(logic [2:0] s);
      tmo_on = 1'b0;
      tmo_cnt = '0;
      fb_on = 1'b0;
      fb_cnt = '0;
      if (s == CODE_DIS_SNK) mode_now = MODE_SNK;
      else if (s == CODE_DIS_SRC) mode_now = MODE_SRC;
      else if (s == CODE_DIS_DRP) mode_now = MODE_DRP;
      st_now = s;
      moved = 1'b1;
   endfunction

   function automatic void enter_disabled();
      case (kind_cfg)
         KIND_SRC: enter_state(CODE_DIS_SRC);
         KIND_SNK: enter_state(CODE_DIS_SNK);
         default:  enter_state(CODE_DIS_DRP);
      endcase
   endfunction

   task automatic attach_predict(input logic [1:0] f, input logic [2:0] t, input logic c,
                                 output attach_report_type r);
      logic src_hit, snk_hit, pulse, t_due, f_due;
      src_hit = (t == TRES_SRC_CC1) || (t == TRES_SRC_CC2);
      snk_hit = (t == TRES_SNK_CC1) || (t == TRES_SNK_CC2);
      pulse = 1'b0;
      t_due = 1'b0;
      f_due = 1'b0;
      moved = 1'b0;
      case (f)
         FUNC_TOGGLE: begin
            if (st_now == CODE_DIS_SNK) begin
               if (snk_hit) enter_state(CODE_UNATT_SNK);
            end else if (st_now == CODE_DIS_SRC) begin
               if (src_hit) enter_state(CODE_ATT_SRC);
            end else if (st_now == CODE_DIS_DRP) begin
               if (snk_hit && !pref_cfg) begin
                  enter_state(CODE_UNATT_SNK);
               end else if (snk_hit) begin
                  enter_state(CODE_DIS_SRC);
                  tmo_cnt = timer_len(try_len);
                  tmo_on = 1'b1;
               end else if (src_hit && pref_cfg) begin
                  enter_state(CODE_ATT_SRC);
               end else if (src_hit) begin
                  pulse = 1'b1;
                  enter_state(CODE_DIS_SNK);
                  tmo_cnt = timer_len(cycle_len);
                  tmo_on = 1'b1;
               end
            end
         end
         FUNC_COMP: begin
            if (st_now == CODE_ATT_SRC && c) enter_disabled();
         end
         FUNC_TICK: begin
            if (tmo_on) begin
               tmo_cnt = tmo_cnt - 16'd1;
               if (tmo_cnt == 16'd0) begin
                  t_due = 1'b1;
                  tmo_on = 1'b0;
               end
            end
            if (fb_on) begin
               fb_cnt = fb_cnt - 16'd1;
               if (fb_cnt == 16'd0) begin
                  f_due = 1'b1;
                  fb_on = 1'b0;
               end
            end
            // timeout wins; a taken transition cancels the fallback
            if (t_due && (st_now == CODE_DIS_SNK || st_now == CODE_DIS_SRC)) begin
               enter_state((st_now == CODE_DIS_SNK) ? CODE_DIS_SRC : CODE_DIS_SNK);
               fb_cnt = timer_len(wait_len);
               fb_on = 1'b1;
            end else if (f_due && (st_now == CODE_DIS_SNK || st_now == CODE_DIS_SRC)) begin
               enter_state(CODE_DIS_DRP);
            end
         end
         default: enter_disabled();
      endcase
      r = '{st_now, mode_now, pulse, tmo_on, fb_on, moved};
   endtask

   task automatic wait_idle();
      if (req_hot) begin
         req_valid <= 1'b0;
         req_hot = 1'b0;
      end
      while (report_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_idle();
      if (csr_hot) begin
         csr_valid <= 1'b0;
         csr_hot = 1'b0;
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_hot = 1'b1;
      case (idx)
         CSR_PORT_KIND:  kind_cfg = val[1:0];
         CSR_PREF_ROLE:  pref_cfg = val[0];
         CSR_TRY:        try_len = val;
         CSR_TRY_WAIT:   wait_len = val;
         CSR_TOGGLE_CYC: cycle_len = val;
         default: ;
      endcase
   endtask

   task automatic push_event(input logic [1:0] f, input logic [2:0] t, input logic c,
                             input logic typed, input attach_report_type want);
      attach_report_type predicted;
      csr_idle();
      req_valid <= 1'b1;
      req_func <= f;
      req_toggle_result <= t;
      req_cmp_detach <= c;
      do @(posedge clock); while (!req_ready);
      attach_predict(f, t, c, predicted);
      report_q.push_back(typed ? want : predicted);
      // hold valid for a back-to-back beat, else drop it for a gap
      if (!no_idle && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         req_hot = 1'b0;
         @(posedge clock);
      end else begin
         req_hot = 1'b1;
      end
   endtask

   task automatic random_event(output logic [1:0] f, output logic [2:0] t, output logic c);
      int unsigned roll;
      roll = $urandom_range(99);
      t = 3'($urandom_range(7));
      c = 1'($urandom_range(1));
      if (roll < 45) begin
         f = FUNC_TICK;
      end else if (roll < 75) begin
         f = FUNC_TOGGLE;
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(3))
               0:       t = TRES_SRC_CC1;
               1:       t = TRES_SRC_CC2;
               2:       t = TRES_SNK_CC1;
               default: t = TRES_SNK_CC2;
            endcase
         end
      end else if (roll < 90) begin
         f = FUNC_COMP;
         if ($urandom_range(3) != 0) c = 1'b1;
      end else begin
         f = FUNC_RESTART;
      end
   endtask

   task automatic load_setting(input int p);
      logic [1:0]  kind;
      logic        pref;
      logic [15:0] try_v, wait_v, cyc_v;
      kind = 2'($urandom_range(3));
      pref = 1'($urandom_range(1));
      try_v = 16'($urandom_range(1, 6));
      wait_v = 16'($urandom_range(1, 6));
      cyc_v = 16'($urandom_range(1, 6));
      case (p)
         0: begin
            kind = KIND_DRP;
            pref = 1'b0;
         end
         1: begin
            kind = KIND_DRP;
            pref = 1'b1;
         end
         2: begin
            try_v = '0;
            wait_v = '0;
            cyc_v = '0;
         end
         3: begin
            kind = KIND_ALT;
            try_v = '1;
            wait_v = '1;
            cyc_v = '1;
         end
         5: kind = KIND_SRC;
         6: kind = KIND_SNK;
         7: begin
            try_v = 16'd1;
            wait_v = 16'd1;
            cyc_v = 16'd1;
         end
         default: ;
      endcase
      csr_write(CSR_PORT_KIND, {14'($urandom), kind});
      csr_write(CSR_PREF_ROLE, {15'($urandom), pref});
      csr_write(CSR_TRY, try_v);
      csr_write(CSR_TRY_WAIT, wait_v);
      csr_write(CSR_TOGGLE_CYC, cyc_v);
   endtask

   task automatic cmp_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_beat
      attach_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (report_q.size() == 0) begin
            $error("rsp beat with no event outstanding");
            fail_count++;
         end else begin
            want = report_q.pop_front();
            cmp_field("conn_state", want.conn_state, rsp_conn_state);
            cmp_field("toggle_mode", want.toggle_mode, rsp_toggle_mode);
            cmp_field("pulldown_pulse", want.pulldown_pulse, rsp_pulldown_pulse);
            cmp_field("timeout_running", want.timeout_running, rsp_timeout_running);
            cmp_field("fallback_running", want.fallback_running, rsp_fallback_running);
            cmp_field("changed", want.changed, rsp_changed);
         end
      end
   end

   initial begin
      logic [1:0] f;
      logic [2:0] t;
      logic       c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) begin
         if (PLAN[i].is_csr) begin
            csr_write(PLAN[i].sel, PLAN[i].data);
         end else begin
            push_event(PLAN[i].sel[1:0], PLAN[i].tres, PLAN[i].comp, PLAN[i].typed,
                       PLAN[i].want);
         end
      end

      for (int p = 0; p < 8; p++) begin
         load_setting(p);
         no_idle = (p == 4);
         for (int n = 0; n < 125; n++) begin
            random_event(f, t, c);
            push_event(f, t, c, 1'b0, NO_WANT);
         end
      end

      csr_idle();
      wait_idle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("** typec_attach_state_machine: PASSED **");
      end else begin
         $display("** typec_attach_state_machine: FAILED **");
      end
      $finish;
   end

endmodule
